### design/cci_pkg.sv
// Shared types, constants and a helper function of the circle collision impulse block.
`timescale 1ns / 1ps

package cci_pkg;

    localparam int PAD_W = 17;
    localparam logic [PAD_W-1:0] PAD_RESET = 17'd1;

    localparam int MUL_AW = 128;
    localparam int MUL_BW = 96;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam int DIV_W = 163;
    localparam int QW = 33;
    localparam int DIV_STEPS = QW;

    typedef struct packed {
        logic signed [31:0] a_center_x;
        logic signed [31:0] a_center_y;
        logic [30:0]        a_radius;
        logic signed [31:0] a_vel_x;
        logic signed [31:0] a_vel_y;
        logic signed [31:0] b_center_x;
        logic signed [31:0] b_center_y;
        logic [30:0]        b_radius;
        logic signed [31:0] b_vel_x;
        logic signed [31:0] b_vel_y;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pulse_x;
        logic signed [31:0] pulse_y;
        logic               coincident;
    } out_t;

    typedef struct packed {
        logic [65:0]        d2;
        logic signed [66:0] s;
        logic [63:0]        cnum;
        logic [63:0]        cden;
        logic [32:0]        ax;
        logic [32:0]        ay;
        logic               sx;
        logic               sy;
        logic               coinc;
    } front_t;

    typedef struct packed {
        logic [DIV_W-1:0] rx;
        logic [DIV_W-1:0] ry;
        logic [DIV_W-1:0] dsh;
        logic [QW-1:0]    qx;
        logic [QW-1:0]    qy;
        logic             negx;
        logic             negy;
        logic             coinc;
    } div_t;

    // Applies sign and saturation to a rounded quotient magnitude; a coincident pair gives zero.
    function automatic logic [31:0] pulse_value(input logic [QW-1:0] q, input logic neg,
                                                input logic coinc);
        logic [31:0] r;
        if (coinc) begin
            r = 32'd0;
        end else if (q[QW-1] || q[31]) begin
            r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = neg ? (32'd0 - q[31:0]) : q[31:0];
        end
        return r;
    endfunction

endpackage

### design/cci_mul.sv
// Three-stage unsigned multiplier built from 32 by 32 bit partial products.
`timescale 1ns / 1ps

module cci_mul import cci_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [MUL_AW-1:0] a,
    input  logic [MUL_BW-1:0] b,
    output logic [MUL_PW-1:0] p
);

    localparam int NA = MUL_AW / 32;
    localparam int NB = MUL_BW / 32;
    localparam int RW = 32 + MUL_BW;

    logic [63:0]       pp_reg [NA][NB];
    logic [RW-1:0]     row_reg [NA];
    logic [MUL_PW-1:0] p_reg;
    logic [RW-1:0]     row_next [NA];
    logic [MUL_PW-1:0] p_next;

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (32 * j));
            end
        end
        p_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            p_next = p_next + (MUL_PW'(row_reg[i]) << (32 * i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= 64'(a[32*i +: 32]) * 64'(b[32*j +: 32]);
                end
                row_reg[i] <= row_next[i];
            end
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

### design/cci_front.sv
// Front stages: differences, squares and dot products, then sums and mass coefficient.
`timescale 1ns / 1ps

module cci_front import cci_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  in_t              in_data,
    input  logic [PAD_W-1:0] pad_threshold,
    output logic             out_valid,
    output front_t           out_data
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [32:0] dx_reg, dy_reg, dvx_reg, dvy_reg;
    logic [30:0]        ra_reg, rb_reg;
    logic               pad1_reg;
    logic signed [32:0] dx_next, dy_next, dvx_next, dvy_next;
    logic               pad1_next;

    logic [64:0]        xx_reg, yy_reg;
    logic signed [65:0] p1_reg, p2_reg;
    logic [61:0]        ra2_reg, rb2_reg;
    logic [32:0]        ax_reg, ay_reg;
    logic               sx_reg, sy_reg, pad2_reg;
    logic signed [65:0] xx_next, yy_next, p1_next, p2_next;
    logic [32:0]        ax_next, ay_next;

    front_t             f_reg;
    front_t             f_next;

    always_comb
    begin
        dx_next   = 33'(in_data.b_center_x) - 33'(in_data.a_center_x);
        dy_next   = 33'(in_data.b_center_y) - 33'(in_data.a_center_y);
        dvx_next  = 33'(in_data.b_vel_x) - 33'(in_data.a_vel_x);
        dvy_next  = 33'(in_data.b_vel_y) - 33'(in_data.a_vel_y);
        pad1_next = 33'(in_data.b_center_y) < $signed({16'd0, pad_threshold});

        xx_next = dx_reg * dx_reg;
        yy_next = dy_reg * dy_reg;
        p1_next = dx_reg * dvx_reg;
        p2_next = dy_reg * dvy_reg;
        ax_next = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ay_next = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);

        f_next.d2    = 66'(xx_reg) + 66'(yy_reg);
        f_next.s     = 67'(p1_reg) + 67'(p2_reg);
        f_next.ax    = ax_reg;
        f_next.ay    = ay_reg;
        f_next.sx    = sx_reg;
        f_next.sy    = sy_reg;
        f_next.coinc = (xx_reg == '0) && (yy_reg == '0);
        if (pad2_reg)
        begin
            f_next.cnum = 64'd2;
            f_next.cden = 64'd1;
        end
        else if ((ra2_reg | rb2_reg) == '0)
        begin
            f_next.cnum = 64'd1;
            f_next.cden = 64'd1;
        end
        else
        begin
            f_next.cnum = {1'b0, rb2_reg, 1'b0};
            f_next.cden = 64'(ra2_reg) + 64'(rb2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            dvx_reg  <= dvx_next;
            dvy_reg  <= dvy_next;
            ra_reg   <= in_data.a_radius;
            rb_reg   <= in_data.b_radius;
            pad1_reg <= pad1_next;

            xx_reg   <= xx_next[64:0];
            yy_reg   <= yy_next[64:0];
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            ra2_reg  <= 62'(ra_reg) * 62'(ra_reg);
            rb2_reg  <= 62'(rb_reg) * 62'(rb_reg);
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            sx_reg   <= dx_reg[32];
            sy_reg   <= dy_reg[32];
            pad2_reg <= pad1_reg;

            f_reg    <= f_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = f_reg;

endmodule

### design/cci_divstep.sv
// One restoring division step that produces one quotient bit for each of the two axes.
`timescale 1ns / 1ps

module cci_divstep import cci_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;
    logic gex, gey;

    always_comb
    begin
        gex = in_data.rx >= in_data.dsh;
        gey = in_data.ry >= in_data.dsh;
        data_next       = in_data;
        data_next.rx    = gex ? (in_data.rx - in_data.dsh) : in_data.rx;
        data_next.ry    = gey ? (in_data.ry - in_data.dsh) : in_data.ry;
        data_next.qx    = {in_data.qx[QW-2:0], gex};
        data_next.qy    = {in_data.qy[QW-2:0], gey};
        data_next.dsh   = in_data.dsh >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### design/circle_collision_impulse.sv
// Top level of the circle collision impulse block: multipliers, divider chain and output buffer.
`timescale 1ns / 1ps

// Accepts one request per clock while in_ready is high; results flow through three front
// stages, two tiers of three-stage multipliers, the 33-stage restoring divider (one quotient
// bit per stage) and a result register. A two-entry output buffer lets a further request in
// while a result waits to be taken; in_ready falls only once both of its entries are full.

module circle_collision_impulse import cci_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [PAD_W-1:0] cfg_data
);

    typedef struct packed {
        logic [65:0] sabs;
        logic        negx;
        logic        negy;
        logic        coinc;
    } side_t;

    typedef struct packed {
        logic [129:0] den;
        logic         negx;
        logic         negy;
        logic         coinc;
    } side2_t;

    logic              en;
    logic [PAD_W-1:0]  pad_reg;
    logic              fv;
    front_t            fd;
    side_t             side_next;
    side_t             side_reg [3];
    side2_t            side2_next;
    side2_t            side2_reg [3];
    logic              mv_reg [6];
    logic [MUL_PW-1:0] px1, py1, pden, px2, py2;
    div_t              prep_next;
    div_t              prep_reg;
    logic              prep_valid_reg;
    div_t              dstage [DIV_STEPS+1];
    logic              dvalid [DIV_STEPS+1];
    out_t              res_next;
    out_t              p_data_reg;
    logic              p_valid_reg;
    logic              take_p;
    out_t              out_data_reg;
    logic              out_valid_reg;
    out_t              skid_data_reg;
    logic              skid_valid_reg;

    assign en        = !skid_valid_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg <= PAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pad_reg <= cfg_data;
        end
    end

    cci_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid && en),
        .in_data       (in_data),
        .pad_threshold (pad_reg),
        .out_valid     (fv),
        .out_data      (fd)
    );

    cci_mul u_mul_x1
    (
        .clk (clk),
        .en  (en),
        .a   ({64'd0, fd.cnum}),
        .b   ({63'd0, fd.ax}),
        .p   (px1)
    );

    cci_mul u_mul_y1
    (
        .clk (clk),
        .en  (en),
        .a   ({64'd0, fd.cnum}),
        .b   ({63'd0, fd.ay}),
        .p   (py1)
    );

    cci_mul u_mul_den
    (
        .clk (clk),
        .en  (en),
        .a   ({64'd0, fd.cden}),
        .b   ({30'd0, fd.d2}),
        .p   (pden)
    );

    cci_mul u_mul_x2
    (
        .clk (clk),
        .en  (en),
        .a   ({31'd0, px1[96:0]}),
        .b   ({30'd0, side_reg[2].sabs}),
        .p   (px2)
    );

    cci_mul u_mul_y2
    (
        .clk (clk),
        .en  (en),
        .a   ({31'd0, py1[96:0]}),
        .b   ({30'd0, side_reg[2].sabs}),
        .p   (py2)
    );

    always_comb
    begin
        side_next.sabs  = fd.s[66] ? 66'(-fd.s) : fd.s[65:0];
        side_next.negx  = fd.sx ^ fd.s[66];
        side_next.negy  = fd.sy ^ fd.s[66];
        side_next.coinc = fd.coinc;

        side2_next.den   = pden[129:0];
        side2_next.negx  = side_reg[2].negx;
        side2_next.negy  = side_reg[2].negy;
        side2_next.coinc = side_reg[2].coinc;

        prep_next.rx    = {px2[161:0], 1'b0} + DIV_W'(side2_reg[2].den);
        prep_next.ry    = {py2[161:0], 1'b0} + DIV_W'(side2_reg[2].den);
        prep_next.dsh   = {side2_reg[2].den, 33'd0};
        prep_next.qx    = '0;
        prep_next.qy    = '0;
        prep_next.negx  = side2_reg[2].negx;
        prep_next.negy  = side2_reg[2].negy;
        prep_next.coinc = side2_reg[2].coinc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                mv_reg[i] <= 1'b0;
            end
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mv_reg[0] <= fv;
            for (int i = 1; i < 6; i++)
            begin
                mv_reg[i] <= mv_reg[i-1];
            end
            prep_valid_reg <= mv_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0]  <= side_next;
            side_reg[1]  <= side_reg[0];
            side_reg[2]  <= side_reg[1];
            side2_reg[0] <= side2_next;
            side2_reg[1] <= side2_reg[0];
            side2_reg[2] <= side2_reg[1];
            prep_reg     <= prep_next;
        end
    end

    assign dstage[0] = prep_reg;
    assign dvalid[0] = prep_valid_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        cci_divstep u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dvalid[k]),
            .in_data   (dstage[k]),
            .out_valid (dvalid[k+1]),
            .out_data  (dstage[k+1])
        );
    end

    always_comb
    begin
        res_next.pulse_x    = pulse_value(dstage[DIV_STEPS].qx, dstage[DIV_STEPS].negx,
                                          dstage[DIV_STEPS].coinc);
        res_next.pulse_y    = pulse_value(dstage[DIV_STEPS].qy, dstage[DIV_STEPS].negy,
                                          dstage[DIV_STEPS].coinc);
        res_next.coincident = dstage[DIV_STEPS].coinc;
    end

    assign take_p = en && p_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                p_valid_reg <= dvalid[DIV_STEPS];
            end
            if (!out_valid_reg || out_ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= take_p;
                end
            end
            else if (take_p)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_data_reg <= res_next;
        end
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : p_data_reg;
        end
        else if (take_p)
        begin
            skid_data_reg <= p_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.coincident |-> out_data.pulse_x == 0 && out_data.pulse_y == 0)
        else $error("coincident result carries a nonzero impulse");

    a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("buffer entry held while output register is empty");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("input stalled without a held output");
`endif

endmodule

### sim/circle_collision_impulse_tb.sv
// Self-checking testbench for the circle collision impulse block with random flow control.
`timescale 1ns / 1ps

module circle_collision_impulse_tb;
    import cci_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 60;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_t              in_data;
    logic             out_valid;
    logic             out_ready;
    out_t             out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [PAD_W-1:0] cfg_data;

    out_t             impulse_expected[$];
    logic [PAD_W-1:0] pad_model;
    int               mismatches;
    int               requests_sent;
    int               results_seen;
    int               coincident_seen;
    int               cycles;
    bit               idling_on;

    circle_collision_impulse dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Rounded quotient magnitude to a signed, saturated 32-bit pulse.
    function automatic logic [31:0] saturate_pulse(logic [199:0] q, bit neg);
        logic [31:0] r;
        if (q >= 200'h8000_0000)
        begin
            r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            r = neg ? 32'd0 - q[31:0] : q[31:0];
        end
        return r;
    endfunction

    function automatic out_t predict_impulse(in_t it, logic [PAD_W-1:0] pad);
        logic signed [67:0] dx;
        logic signed [67:0] dy;
        logic signed [67:0] dvx;
        logic signed [67:0] dvy;
        logic signed [67:0] d2;
        logic signed [67:0] s;
        logic [199:0]       s_mag;
        logic [199:0]       dx_mag;
        logic [199:0]       dy_mag;
        logic [199:0]       ra2;
        logic [199:0]       rb2;
        logic [199:0]       cnum;
        logic [199:0]       cden;
        logic [199:0]       den;
        logic [199:0]       qx;
        logic [199:0]       qy;
        out_t               r;
        dx  = 68'(it.b_center_x) - 68'(it.a_center_x);
        dy  = 68'(it.b_center_y) - 68'(it.a_center_y);
        dvx = 68'(it.b_vel_x) - 68'(it.a_vel_x);
        dvy = 68'(it.b_vel_y) - 68'(it.a_vel_y);
        d2  = dx * dx + dy * dy;
        r = '0;
        if (d2 == 0)
        begin
            r.coincident = 1'b1;
            return r;
        end
        s = dx * dvx + dy * dvy;
        s_mag  = 200'(s < 0 ? -s : s);
        dx_mag = 200'(dx < 0 ? -dx : dx);
        dy_mag = 200'(dy < 0 ? -dy : dy);
        ra2 = 200'(it.a_radius) * 200'(it.a_radius);
        rb2 = 200'(it.b_radius) * 200'(it.b_radius);
        if (it.b_center_y < $signed({15'd0, pad}))
        begin
            cnum = 200'd2;
            cden = 200'd1;
        end
        else if (ra2 + rb2 == 0)
        begin
            cnum = 200'd1;
            cden = 200'd1;
        end
        else
        begin
            cnum = 200'd2 * rb2;
            cden = ra2 + rb2;
        end
        den = cden * 200'(d2);
        qx = (200'd2 * cnum * dx_mag * s_mag + den) / (200'd2 * den);
        qy = (200'd2 * cnum * dy_mag * s_mag + den) / (200'd2 * den);
        r.pulse_x = saturate_pulse(qx, (dx < 0) != (s < 0));
        r.pulse_y = saturate_pulse(qy, (dy < 0) != (s < 0));
        return r;
    endfunction

    function automatic logic signed [31:0] rand_coord(int mode);
        logic signed [31:0] v;
        case (mode)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: v = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        endcase
        return v;
    endfunction

    function automatic in_t random_collision();
        in_t it;
        int  mode;
        int  special;
        mode    = $urandom_range(0, 2);
        special = $urandom_range(0, 9);
        it.a_center_x = rand_coord(mode);
        it.a_center_y = rand_coord(mode);
        it.b_center_x = rand_coord(mode);
        it.b_center_y = rand_coord(mode);
        it.a_vel_x    = rand_coord(mode);
        it.a_vel_y    = rand_coord(mode);
        it.b_vel_x    = rand_coord(mode);
        it.b_vel_y    = rand_coord(mode);
        it.a_radius   = mode == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0004_0000));
        it.b_radius   = mode == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0004_0000));
        if (special == 0)
        begin
            it.b_center_x = it.a_center_x;
            it.b_center_y = it.a_center_y;
        end
        else if (special == 1)
        begin
            it.a_radius = '0;
            it.b_radius = '0;
        end
        else if (special == 2)
        begin
            it.b_center_y = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0000_8000;
        end
        return it;
    endfunction

    task automatic send_collision(in_t it);
        while (idling_on && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        impulse_expected.push_back(predict_impulse(it, pad_model));
        requests_sent++;
    endtask

    task automatic write_pad_threshold(logic [PAD_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (impulse_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pad_model = value;
    endtask

    function automatic in_t make_collision(logic signed [31:0] ax, logic signed [31:0] ay,
                                           logic signed [31:0] bx, logic signed [31:0] by,
                                           logic signed [31:0] vx, logic signed [31:0] vy,
                                           logic [30:0] ra, logic [30:0] rb);
        in_t it;
        it = '0;
        it.a_center_x = ax;
        it.a_center_y = ay;
        it.b_center_x = bx;
        it.b_center_y = by;
        it.b_vel_x    = vx;
        it.b_vel_y    = vy;
        it.a_radius   = ra;
        it.b_radius   = rb;
        return it;
    endfunction

    task automatic test_directed();
        in_t it;
        send_collision(make_collision(0, 0, 32'sh0002_0000, 32'sh0001_0000,
                                      32'sh0001_0000, 0, 31'h0001_0000, 31'h0001_0000));
        send_collision(make_collision(5, 5, 5, 5, 32'sh7FFF_FFFF, 1, 31'h7FFF_FFFF, 3));
        send_collision(make_collision(0, 32'sh0010_0000, 1, 32'sh0010_0001, 1, 0, 0, 0));
        send_collision(make_collision(0, 32'sh0010_0000, 1, 32'sh0010_0001, -1, 0, 0, 0));
        send_collision(make_collision(0, 0, 2, -4, 1, 0, 31'd9, 31'd3));
        send_collision(make_collision(0, 0, 2, 0, 1, 0, 31'd9, 31'd3));
        it = '1;
        send_collision(it);
        it = '0;
        send_collision(it);
        send_collision(make_collision(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                      31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_collision(make_collision(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                      31'h7FFF_FFFF, 0));
        send_collision(make_collision(0, 32'sh4000_0000, 1, 32'sh4000_0000,
                                      32'sh7FFF_FFFF, 0, 0, 31'h7FFF_FFFF));
        it = make_collision(1, 2, 3, 4, 5, 6, 31'h5555_5555, 31'h2AAA_AAAA);
        it.a_vel_x = 32'sh8000_0000;
        it.a_vel_y = 32'sh7FFF_FFFF;
        send_collision(it);
        send_collision(make_collision(0, -1, 0, 0, 0, 32'sh0001_0000, 1, 1));
    endtask

    task automatic test_random(int count);
        repeat (count) send_collision(random_collision());
    endtask

    task automatic test_back_to_back(int count);
        idling_on = 1'b0;
        test_random(count);
        idling_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !idling_on || $urandom_range(0, 99) >= 29;
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (impulse_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %h", out_data);
                end
            end
            else
            begin
                want = impulse_expected.pop_front();
                if (want.coincident)
                begin
                    coincident_seen++;
                end
                if (out_data.pulse_x !== want.pulse_x || out_data.pulse_y !== want.pulse_y
                    || out_data.coincident !== want.coincident)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected x=%h y=%h c=%b, got x=%h y=%h c=%b",
                                 want.pulse_x, want.pulse_y, want.coincident,
                                 out_data.pulse_x, out_data.pulse_y, out_data.coincident);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        out_ready       = 1'b0;
        pad_model       = PAD_RESET;
        mismatches      = 0;
        requests_sent   = 0;
        results_seen    = 0;
        coincident_seen = 0;
        cycles          = 0;
        idling_on       = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300);
        write_pad_threshold(17'd0);
        test_directed();
        test_random(300);
        write_pad_threshold(17'h1_0000);
        test_directed();
        test_back_to_back(300);
        write_pad_threshold(17'($urandom_range(0, 32'h1_0000)));
        test_random(300);
        write_pad_threshold(17'h0_FFFF);
        test_random(300);
        write_pad_threshold(17'd1);
        test_random(150);
        in_valid <= 1'b0;
        while (impulse_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d collision requests over six pad thresholds, %0d results checked",
                 requests_sent, results_seen);
        $display("%0d coincident results, %0d mismatches", coincident_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
